// ----- rtl/fct_pkg.sv -----
// Shared types, constants and helper functions for the allocation table engine.
package fct_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned LinkW      = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [LinkW-1:0] EndMarker = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_ALLOC  = 3'd0,
    MODE_FREE   = 3'd1,
    MODE_LAST   = 3'd2,
    MODE_OFFSET = 3'd3,
    MODE_READ   = 3'd4,
    MODE_WRITE  = 3'd5
  } fct_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } fct_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE   = 1'b0,
    CFG_TABLE_BLOCKS = 1'b1
  } fct_cfg_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] start_index;
    logic [15:0] write_value;
    logic [31:0] byte_len;
  } fct_cmd_t;

  typedef struct packed {
    logic [15:0] result_index;
    logic [31:0] byte_offset;
    logic [1:0]  status;
  } fct_res_t;

  typedef struct packed {
    logic             re;
    logic [IdxW-1:0]  raddr;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [LinkW-1:0] wdata;
  } fct_mem_req_t;

  // log2 of the effective block size; unsupported sizes behave as 256
  function automatic logic [3:0] blk_shift(logic [12:0] bs);
    logic [3:0] sh;
    case (bs)
      13'd256:  sh = 4'd8;
      13'd512:  sh = 4'd9;
      13'd1024: sh = 4'd10;
      13'd2048: sh = 4'd11;
      13'd4096: sh = 4'd12;
      default:  sh = 4'd8;
    endcase
    return sh;
  endfunction

  // entries in use: table bytes / 2, capped at the table depth
  function automatic logic [CntW-1:0] used_calc(logic [5:0] tbc, logic [3:0] sh);
    logic [31:0] raw;
    raw = {26'd0, tbc} << (sh - 4'd1);
    if (raw > 32'(TableDepth)) begin
      return CntW'(TableDepth);
    end
    return raw[CntW-1:0];
  endfunction

  function automatic logic chain_ok(logic [LinkW-1:0] i, logic [CntW-1:0] used);
    return (i != '0) && (i < LinkW'(used));
  endfunction

endpackage

// ----- rtl/fct_link_mem.sv -----
// Link table memory with post-reset clearing sweep and write-to-read bypass.
module fct_link_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fct_pkg::fct_mem_req_t       req_i,
  output logic [fct_pkg::LinkW-1:0]   rdata_o,
  output logic                        clearing_o
);
  import fct_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  logic [LinkW-1:0] mem [TableDepth];
  logic [LinkW-1:0] rd_q;
  logic [LinkW-1:0] byp_data_q;
  logic             byp_q;
  logic             clr_q;
  logic [IdxW-1:0]  clr_cnt_q;

  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [LinkW-1:0] wdata;

  always_comb begin
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else begin
      we    = req_i.we;
      waddr = req_i.waddr;
      wdata = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
    byp_data_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      byp_q     <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
        if (clr_cnt_q == LastIdx) begin
          clr_q <= 1'b0;
        end
      end
      if (req_i.re) begin
        byp_q <= we && (waddr == req_i.raddr);
      end
    end
  end

  assign rdata_o    = byp_q ? byp_data_q : rd_q;
  assign clearing_o = clr_q;

endmodule

// ----- rtl/fat_chain_table_engine_top.sv -----
// Top level of the allocation table engine: command sequencer and configuration.
//
// After reset the 1024-entry link table is swept to zero with busy_o high; configuration writes
// are taken during the sweep. An item is taken when start_i is high and busy_o low; its result
// shows on res_o for one cycle with done_o and cannot be held off. Operations with no walk
// (rejected indices, write entry, allocate on an empty table) answer the cycle after the
// transfer and leave busy_o low; read entry answers after the read state. Allocate visits
// one entry per cycle from index 1, up to the last entry in use; free chain, find last and
// end offset follow the chain link by link. The single port pair of the link memory, with
// its registered read, sets this pace.
module fat_chain_table_engine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  fct_pkg::fct_cmd_t              cmd_i,
  output logic                           done_o,
  output fct_pkg::fct_res_t              res_o,
  input  logic                           cfg_we_i,
  input  logic [fct_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fct_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import fct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FREE = 5'b00100,
    S_WALK = 5'b01000,
    S_READ = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [12:0]      bs_q;
  logic [5:0]       tbc_q;
  logic [2:0]       mode_q, mode_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [31:0]      acc_q, acc_d;
  logic             done_q, done_d;
  fct_res_t         res_q, res_d;

  fct_mem_req_t     req;
  logic [LinkW-1:0] rdata;
  logic             clearing;

  logic [3:0]       shift;
  logic [CntW-1:0]  used;
  logic             accept;
  logic [CntW-1:0]  nxt_scan;
  logic [31:0]      diff;

  fct_link_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  assign shift    = blk_shift(bs_q);
  assign used     = used_calc(tbc_q, shift);
  assign busy_o   = clearing || (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign nxt_scan = CntW'(cur_q) + CntW'(1);
  assign diff     = 32'(cur_q) - 32'd1 - 32'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= 13'd256;
      tbc_q <= 6'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE:   bs_q  <= cfg_wdata_i;
        CFG_TABLE_BLOCKS: tbc_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    res_d   = '0;
    req     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = cmd_i.mode;
          cur_d  = cmd_i.start_index[IdxW-1:0];
          cnt_d  = '0;
          acc_d  = cmd_i.byte_len + (32'(tbc_q) << shift);
          case (cmd_i.mode)
            MODE_ALLOC: begin
              if (used <= CntW'(1)) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                req.re    = 1'b1;
                req.raddr = IdxW'(1);
                cur_d     = IdxW'(1);
                state_d   = S_SCAN;
              end
            end
            MODE_FREE, MODE_LAST, MODE_OFFSET: begin
              if (cmd_i.mode == MODE_OFFSET && cmd_i.start_index == '0) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else if (!chain_ok(cmd_i.start_index, used)) begin
                done_d       = 1'b1;
                res_d.status = ST_BAD;
              end else begin
                req.re    = 1'b1;
                req.raddr = cmd_i.start_index[IdxW-1:0];
                state_d   = (cmd_i.mode == MODE_FREE) ? S_FREE : S_WALK;
              end
            end
            MODE_READ: begin
              if (cmd_i.start_index < LinkW'(used)) begin
                req.re    = 1'b1;
                req.raddr = cmd_i.start_index[IdxW-1:0];
                state_d   = S_READ;
              end else begin
                done_d       = 1'b1;
                res_d.status = ST_BAD;
              end
            end
            MODE_WRITE: begin
              done_d = 1'b1;
              if (chain_ok(cmd_i.start_index, used)) begin
                req.we    = 1'b1;
                req.waddr = cmd_i.start_index[IdxW-1:0];
                req.wdata = cmd_i.write_value;
              end else begin
                res_d.status = ST_BAD;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_d.status = ST_BAD;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rdata == '0) begin
          req.we             = 1'b1;
          req.waddr          = cur_q;
          req.wdata          = EndMarker;
          done_d             = 1'b1;
          res_d.result_index = 16'(cur_q);
          state_d            = S_IDLE;
        end else if (nxt_scan >= used) begin
          done_d       = 1'b1;
          res_d.status = ST_EMPTY;
          state_d      = S_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = nxt_scan[IdxW-1:0];
          cur_d     = nxt_scan[IdxW-1:0];
        end
      end

      S_FREE: begin
        req.we    = 1'b1;
        req.waddr = cur_q;
        req.wdata = '0;
        if (rdata == EndMarker) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!chain_ok(rdata, used) || cnt_q >= used) begin
          done_d       = 1'b1;
          res_d.status = ST_BAD;
          state_d      = S_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = rdata[IdxW-1:0];
          cur_d     = rdata[IdxW-1:0];
          cnt_d     = cnt_q + CntW'(1);
        end
      end

      S_WALK: begin
        if (rdata == EndMarker) begin
          done_d             = 1'b1;
          res_d.result_index = 16'(cur_q);
          if (mode_q == MODE_OFFSET) begin
            res_d.byte_offset = acc_q + (diff << shift);
          end
          state_d = S_IDLE;
        end else if (!chain_ok(rdata, used) || cnt_q >= used) begin
          done_d       = 1'b1;
          res_d.status = ST_BAD;
          state_d      = S_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = rdata[IdxW-1:0];
          cur_d     = rdata[IdxW-1:0];
          cnt_d     = cnt_q + CntW'(1);
        end
      end

      S_READ: begin
        done_d             = 1'b1;
        res_d.result_index = rdata;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cur_q  <= cur_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE)
    else $error("result strobe while a walk is still running");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_FREE) |-> cnt_q <= used)
    else $error("link count ran past entries in use");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!done_o && state_q == S_IDLE))
    else $error("activity during the clearing sweep");

  a_alloc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && mode_q == MODE_ALLOC && res_o.status == ST_OK) |-> res_o.result_index != '0)
    else $error("allocate handed out the reserved entry");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (cur_q != '0 && CntW'(cur_q) < used))
    else $error("free-entry scan outside entries in use");

endmodule
